@@ sv/dsfv_pkg.sv @@
// ----------------------------------------------------------------------------
// dsfv_pkg
// Shared types and constants of the dual sensor fault voter.
// ----------------------------------------------------------------------------
package dsfv_pkg;

  localparam int unsigned ReadingWidth = 16;
  localparam int unsigned FaultWidth   = 4;
  localparam int unsigned StuckWidth   = 12;
  localparam int unsigned DevWidth     = 15;
  localparam int unsigned PaddrWidth   = 4;
  localparam int unsigned PdataWidth   = 32;
  localparam int unsigned CountWidth   = 2;

  // Q3.12 value -1.0 marks a sensor that is not working
  localparam logic signed [ReadingWidth-1:0] Marker = -16'sd4096;

  // Fault bit positions
  localparam int unsigned FltStuck   = 0;
  localparam int unsigned FltDev     = 1;
  localparam int unsigned FltDead    = 2;
  localparam int unsigned FltRange   = 3;

  // Register indexes (byte address is 4 * index)
  localparam logic [1:0] RegStuckThr  = 2'd0;
  localparam logic [1:0] RegDevLimit  = 2'd1;
  localparam logic [1:0] RegRangeLow  = 2'd2;
  localparam logic [1:0] RegRangeHigh = 2'd3;

  // Reset values of the registers
  localparam logic [StuckWidth-1:0]          StuckThrRst  = 12'd41;
  localparam logic [DevWidth-1:0]            DevLimitRst  = 15'd8192;
  localparam logic signed [ReadingWidth-1:0] RangeLowRst  = 16'sd4096;
  localparam logic signed [ReadingWidth-1:0] RangeHighRst = 16'sd20480;

  typedef struct packed {
    logic signed [ReadingWidth-1:0] reading_a;
    logic signed [ReadingWidth-1:0] reading_b;
    logic                           series_start;
  } in_t;

  typedef struct packed {
    logic signed [ReadingWidth-1:0] voted_value;
    logic [FaultWidth-1:0]          faults_a;
    logic [FaultWidth-1:0]          faults_b;
  } out_t;

  typedef struct packed {
    logic [StuckWidth-1:0]          stuck_threshold;
    logic [DevWidth-1:0]            deviation_limit;
    logic signed [ReadingWidth-1:0] range_low;
    logic signed [ReadingWidth-1:0] range_high;
  } cfg_t;

endpackage

@@ sv/dsfv_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dsfv_cfg_regs
// APB register bank holding the fault thresholds and range bounds.
// ----------------------------------------------------------------------------
module dsfv_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dsfv_pkg::PaddrWidth-1:0]      paddr,
  input  logic [dsfv_pkg::PdataWidth-1:0]      pwdata,
  output logic [dsfv_pkg::PdataWidth-1:0]      prdata,
  output logic                                 pready,
  output dsfv_pkg::cfg_t                       cfg_o
);

  dsfv_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stuck_threshold <= dsfv_pkg::StuckThrRst;
      cfg_q.deviation_limit <= dsfv_pkg::DevLimitRst;
      cfg_q.range_low       <= dsfv_pkg::RangeLowRst;
      cfg_q.range_high      <= dsfv_pkg::RangeHighRst;
    end else if (wr_en) begin
      case (reg_idx)
        dsfv_pkg::RegStuckThr: begin
          cfg_q.stuck_threshold <= pwdata[dsfv_pkg::StuckWidth-1:0];
        end
        dsfv_pkg::RegDevLimit: begin
          cfg_q.deviation_limit <= pwdata[dsfv_pkg::DevWidth-1:0];
        end
        dsfv_pkg::RegRangeLow: begin
          cfg_q.range_low <= pwdata[dsfv_pkg::ReadingWidth-1:0];
        end
        dsfv_pkg::RegRangeHigh: begin
          cfg_q.range_high <= pwdata[dsfv_pkg::ReadingWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dsfv_pkg::RegStuckThr: begin
        prdata = {20'd0, cfg_q.stuck_threshold};
      end
      dsfv_pkg::RegDevLimit: begin
        prdata = {17'd0, cfg_q.deviation_limit};
      end
      dsfv_pkg::RegRangeLow: begin
        prdata = {{16{cfg_q.range_low[15]}}, cfg_q.range_low};
      end
      dsfv_pkg::RegRangeHigh: begin
        prdata = {{16{cfg_q.range_high[15]}}, cfg_q.range_high};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/dsfv_sensor_check.sv @@
// ----------------------------------------------------------------------------
// dsfv_sensor_check
// Fault flags of one sensor from its reading and its two previous readings.
// ----------------------------------------------------------------------------
module dsfv_sensor_check (
  input  logic signed [dsfv_pkg::ReadingWidth-1:0] reading_i,
  input  logic signed [dsfv_pkg::ReadingWidth-1:0] prev0_i,
  input  logic signed [dsfv_pkg::ReadingWidth-1:0] prev1_i,
  input  logic [dsfv_pkg::CountWidth-1:0]          count_i,
  input  dsfv_pkg::cfg_t                           cfg_i,
  output logic [dsfv_pkg::FaultWidth-1:0]          faults_o
);

  // Exact magnitude of a difference of two 16-bit signed values
  function automatic logic [15:0] abs_diff(input logic signed [15:0] x,
                                           input logic signed [15:0] y);
    logic signed [16:0] d;
    logic signed [16:0] m;
    d = 17'(x) - 17'(y);
    m = d[16] ? -d : d;
    return m[15:0];
  endfunction

  logic [15:0] step_now;
  logic [15:0] step_old;
  logic        is_dead;
  logic        prev_dead;

  assign step_now  = abs_diff(reading_i, prev0_i);
  assign step_old  = abs_diff(prev0_i, prev1_i);
  assign is_dead   = (reading_i == dsfv_pkg::Marker);
  assign prev_dead = (prev0_i == dsfv_pkg::Marker);

  always_comb begin
    faults_o = '0;
    faults_o[dsfv_pkg::FltStuck] = (count_i >= 2'd2)
                                   && (step_now < {4'd0, cfg_i.stuck_threshold})
                                   && (step_old < {4'd0, cfg_i.stuck_threshold});
    faults_o[dsfv_pkg::FltDev]   = (count_i >= 2'd1)
                                   && (step_now > {1'b0, cfg_i.deviation_limit})
                                   && !is_dead && !prev_dead;
    faults_o[dsfv_pkg::FltDead]  = is_dead;
    faults_o[dsfv_pkg::FltRange] = (reading_i <= cfg_i.range_low)
                                   || (reading_i > cfg_i.range_high);
  end

endmodule

@@ sv/dual_sensor_fault_voter.sv @@
// ----------------------------------------------------------------------------
// dual_sensor_fault_voter
// Checks two redundant sensor readings for faults and votes one value.
//
//   channel   direction  handshake                   payload
//   in        input      in_valid_i / in_stall_o     in_data_i  (in_t)
//   out       output     out_valid_o / out_stall_i   out_data_o (out_t)
//   config    input      APB psel/penable/pwrite     paddr, pwdata, prdata
//
// One item per cycle sustained while the output is not stalled; an item passes
// the input register and then the result register before it is offered out.
// Fault checks and the vote sit between the two registers; the history
// of readings advances as an item moves into the result register.
// Reset clears the history and the sample count and loads register defaults.
// While a result is stalled the input register still takes one more item.
// ----------------------------------------------------------------------------
module dual_sensor_fault_voter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  dsfv_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output dsfv_pkg::out_t                       out_data_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dsfv_pkg::PaddrWidth-1:0]      paddr,
  input  logic [dsfv_pkg::PdataWidth-1:0]      pwdata,
  output logic [dsfv_pkg::PdataWidth-1:0]      prdata,
  output logic                                 pready
);

  dsfv_pkg::cfg_t cfg;

  logic           s1_valid_q;
  dsfv_pkg::in_t  s1_data_q;
  logic           out_valid_q;
  dsfv_pkg::out_t out_data_q;
  dsfv_pkg::out_t out_data_d;

  logic signed [dsfv_pkg::ReadingWidth-1:0] prev_a0_q, prev_a1_q;
  logic signed [dsfv_pkg::ReadingWidth-1:0] prev_b0_q, prev_b1_q;
  logic [dsfv_pkg::CountWidth-1:0]          seen_q, seen_d;
  logic [dsfv_pkg::CountWidth-1:0]          count;

  logic                                     in_xfer;
  logic                                     s1_adv;
  logic [dsfv_pkg::FaultWidth-1:0]          faults_a, faults_b;
  logic signed [dsfv_pkg::ReadingWidth:0]   sum;
  logic signed [dsfv_pkg::ReadingWidth:0]   mean;

  dsfv_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the input register when the result register is free or draining
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // A new series ignores the history for this sample
  assign count  = s1_data_q.series_start ? '0 : seen_q;
  assign seen_d = (count >= 2'd2) ? 2'd2 : count + 2'd1;

  dsfv_sensor_check u_check_a (
    .reading_i (s1_data_q.reading_a),
    .prev0_i   (prev_a0_q),
    .prev1_i   (prev_a1_q),
    .count_i   (count),
    .cfg_i     (cfg),
    .faults_o  (faults_a)
  );

  dsfv_sensor_check u_check_b (
    .reading_i (s1_data_q.reading_b),
    .prev0_i   (prev_b0_q),
    .prev1_i   (prev_b1_q),
    .count_i   (count),
    .cfg_i     (cfg),
    .faults_o  (faults_b)
  );

  // Floor of the mean: arithmetic shift of the 17-bit sum
  assign sum  = 17'(s1_data_q.reading_a) + 17'(s1_data_q.reading_b);
  assign mean = sum >>> 1;

  always_comb begin
    out_data_d.faults_a = faults_a;
    out_data_d.faults_b = faults_b;
    if (faults_a == '0 && faults_b == '0) begin
      out_data_d.voted_value = mean[dsfv_pkg::ReadingWidth-1:0];
    end else if (faults_a == '0) begin
      out_data_d.voted_value = s1_data_q.reading_a;
    end else if (faults_b == '0) begin
      out_data_d.voted_value = s1_data_q.reading_b;
    end else begin
      out_data_d.voted_value = dsfv_pkg::Marker;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a0_q <= '0;
      prev_a1_q <= '0;
      prev_b0_q <= '0;
      prev_b1_q <= '0;
      seen_q    <= '0;
    end else if (s1_adv) begin
      prev_a0_q <= s1_data_q.reading_a;
      prev_a1_q <= prev_a0_q;
      prev_b0_q <= s1_data_q.reading_b;
      prev_b1_q <= prev_b0_q;
      seen_q    <= seen_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_stall_holds_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_seen_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != 2'd3)
    else $error("sample count passed saturation");

  a_both_failed_marker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.faults_a != '0 && out_data_o.faults_b != '0)
      |-> (out_data_o.voted_value == dsfv_pkg::Marker))
    else $error("both sensors failed but vote is not the marker");

  a_history_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (prev_a0_q == $past(s1_data_q.reading_a))
               && (prev_b0_q == $past(s1_data_q.reading_b)))
    else $error("history did not take the transferred readings");

  a_stuck_needs_history : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_data_q.series_start)
      |-> (faults_a[dsfv_pkg::FltStuck] == 1'b0 && faults_b[dsfv_pkg::FltStuck] == 1'b0))
    else $error("stuck flagged on first sample of a series");
`endif

endmodule
